### hdl/aes128_xts_block_cipher_unit_macros.svh
// Assertion macros for the XTS cipher unit
`ifndef AES128_XTS_BLOCK_CIPHER_UNIT_MACROS_SVH
`define AES128_XTS_BLOCK_CIPHER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define XTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define XTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/xts_pkg.sv
// Shared types, tables and round functions for the XTS cipher unit
package xts_pkg;

    typedef logic [7:0] t_sbox [256];

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_KEY_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_KEY_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TWEAK_KEY_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TWEAK_KEY_HIGH = 2'd3;

    localparam logic KIND_TWEAK = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    localparam int NUM_ROUNDS = 10;

    localparam t_sbox SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // worked out at elaboration
    function automatic t_sbox f_inv_sbox();
        t_sbox r;
        for (int i = 0; i < 256; i++) begin
            r[SBOX[i]] = 8'(i);
        end
        return r;
    endfunction

    localparam t_sbox INV_SBOX = f_inv_sbox();

    localparam logic [7:0] RCON [NUM_ROUNDS+1] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [127:0] GF_POLY = 128'h87;

    // one item's worth of round state, handed from cell to cell
    typedef struct packed {
        logic         valid;
        logic         kind;
        logic         dec;
        logic         last;
        logic [127:0] state;
        logic [127:0] rkey;
        logic [127:0] tweak;
    } t_cell;

    function automatic logic [7:0] f_xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] f_sub_rot(input logic [31:0] w, input logic [7:0] rc);
        return {SBOX[w[7:0]], SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]] ^ rc};
    endfunction

    function automatic logic [127:0] f_key_next(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] n0, n1, n2, n3;
        n0 = k[31:0] ^ f_sub_rot(k[127:96], rc);
        n1 = k[63:32] ^ n0;
        n2 = k[95:64] ^ n1;
        n3 = k[127:96] ^ n2;
        return {n3, n2, n1, n0};
    endfunction

    function automatic logic [127:0] f_key_prev(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] p0, p1, p2, p3;
        p3 = k[127:96] ^ k[95:64];
        p2 = k[95:64] ^ k[63:32];
        p1 = k[63:32] ^ k[31:0];
        p0 = k[31:0] ^ f_sub_rot(p3, rc);
        return {p3, p2, p1, p0};
    endfunction

    function automatic logic [31:0] f_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[7:0];
        a1 = c[15:8];
        a2 = c[23:16];
        a3 = c[31:24];
        return {f_xtime(a0) ^ a0 ^ a1 ^ a2 ^ f_xtime(a3),
                a0 ^ a1 ^ f_xtime(a2) ^ f_xtime(a3) ^ a3,
                a0 ^ f_xtime(a1) ^ f_xtime(a2) ^ a2 ^ a3,
                f_xtime(a0) ^ f_xtime(a1) ^ a1 ^ a2 ^ a3};
    endfunction

    function automatic logic [31:0] f_inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        logic [7:0] x1 [4];
        logic [7:0] x2 [4];
        logic [7:0] x3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        a0 = c[7:0];
        a1 = c[15:8];
        a2 = c[23:16];
        a3 = c[31:24];
        x1[0] = a0; x1[1] = a1; x1[2] = a2; x1[3] = a3;
        for (int i = 0; i < 4; i++) begin
            x2[i] = f_xtime(x1[i]);
            x3[i] = f_xtime(x2[i]);
            m9[i] = f_xtime(x3[i]) ^ x1[i];
            mb[i] = m9[i] ^ x2[i];
            md[i] = m9[i] ^ x3[i];
            me[i] = f_xtime(x3[i]) ^ x3[i] ^ x2[i];
        end
        return {mb[0] ^ md[1] ^ m9[2] ^ me[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                me[0] ^ mb[1] ^ md[2] ^ m9[3]};
    endfunction

endpackage

### hdl/xts_in_if.sv
// Input channel: tweak or data block items
interface xts_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic        decrypt;
    logic        last_block;

    modport source (output valid, kind, block_low, block_high, decrypt, last_block,
                    input ready);
    modport sink   (input valid, kind, block_low, block_high, decrypt, last_block,
                    output ready);
endinterface

### hdl/xts_out_if.sv
// Output channel: processed block items
interface xts_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        last;

    modport source (output valid, result_low, result_high, last, input ready);
    modport sink   (input valid, result_low, result_high, last, output ready);
endinterface

### hdl/aes128_xts_block_cipher_unit.sv
// Top level: AES-128 XTS block unit built as a chain of round cells
//
//  channel | dir | carries                                     | handshake
//  i_in    | in  | kind, block_low/high, decrypt, last_block   | valid/ready
//  o_out   | out | result_low/high, last                       | valid/ready
//  cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data             | write only
//
// One data item a cycle while no stalled output, tweak in flight or key rebuild
// holds the input; its result passes the entry register, ten round cells and the output register.
// A tweak item blocks the input until it leaves the last cell.
// After reset or a data key write, the final round key is rebuilt and the input
// is held meanwhile. A stalled output freezes the whole chain.
`include "aes128_xts_block_cipher_unit_macros.svh"

module aes128_xts_block_cipher_unit
    import xts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    xts_in_if.sink               i_in,
    xts_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);

    logic [127:0] r_data_key;
    logic [127:0] r_tweak_key;
    logic         r_dk_wr;
    logic [127:0] r_tweak;
    logic [127:0] n_tweak;
    t_cell        r_s0;
    t_cell        n_s0;
    t_cell        w_st [NUM_ROUNDS+1];
    logic         r_out_valid;
    logic [127:0] r_out_data;
    logic         r_out_last;
    logic [127:0] w_dec_key;
    logic         w_key_busy;
    logic         w_adv;
    logic         w_accept;
    logic         w_tw_pending;
    logic [127:0] w_blk;
    logic         w_dec;
    t_cell        w_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_key  <= '0;
            r_tweak_key <= '0;
            r_dk_wr     <= 1'b1;
        end else begin
            r_dk_wr <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DATA_KEY_LOW: begin
                        r_data_key[63:0] <= i_cfg_data;
                        r_dk_wr          <= 1'b1;
                    end
                    REG_DATA_KEY_HIGH: begin
                        r_data_key[127:64] <= i_cfg_data;
                        r_dk_wr            <= 1'b1;
                    end
                    REG_TWEAK_KEY_LOW:  r_tweak_key[63:0]   <= i_cfg_data;
                    REG_TWEAK_KEY_HIGH: r_tweak_key[127:64] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    xts_key_sched u_key_sched (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dk_wr),
        .i_key      (r_data_key),
        .o_last_key (w_dec_key),
        .o_busy     (w_key_busy)
    );

    assign w_tail = w_st[NUM_ROUNDS];
    assign w_adv  = !r_out_valid || o_out.ready;

    // a tweak item in flight blocks all input items until the tweak is known
    always_comb begin
        w_tw_pending = 1'b0;
        for (int s = 0; s <= NUM_ROUNDS; s++) begin
            w_tw_pending = w_tw_pending || (w_st[s].valid && (w_st[s].kind == KIND_TWEAK));
        end
    end

    assign i_in.ready = w_adv && !w_tw_pending && !w_key_busy;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_blk = {i_in.block_high, i_in.block_low};
    assign w_dec = (i_in.kind == KIND_DATA) && i_in.decrypt;

    always_comb begin
        n_s0       = r_s0;
        n_s0.valid = w_accept;
        n_s0.kind  = i_in.kind;
        n_s0.dec   = w_dec;
        n_s0.last  = i_in.last_block;
        n_s0.tweak = r_tweak;
        if (i_in.kind == KIND_TWEAK) begin
            n_s0.rkey = r_tweak_key;
        end else if (w_dec) begin
            n_s0.rkey = w_dec_key;
        end else begin
            n_s0.rkey = r_data_key;
        end
        n_s0.state = w_blk ^ n_s0.rkey ^ ((i_in.kind == KIND_DATA) ? r_tweak : '0);
    end

    always_comb begin
        n_tweak = r_tweak;
        if (w_accept && (i_in.kind == KIND_DATA)) begin
            n_tweak = {r_tweak[126:0], 1'b0} ^ (r_tweak[127] ? GF_POLY : '0);
        end else if (w_adv && w_tail.valid && (w_tail.kind == KIND_TWEAK)) begin
            n_tweak = w_tail.state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid  <= 1'b0;
            r_tweak     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_tweak <= n_tweak;
            if (w_adv) begin
                r_s0        <= n_s0;
                r_out_valid <= w_tail.valid && (w_tail.kind == KIND_DATA);
                r_out_data  <= w_tail.state ^ w_tail.tweak;
                r_out_last  <= w_tail.last;
            end
        end
    end

    assign w_st[0] = r_s0;

    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_cell
        xts_round_cell #(
            .ROUND (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_d     (w_st[g-1]),
            .o_q     (w_st[g])
        );
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_low  = r_out_data[63:0];
    assign o_out.result_high = r_out_data[127:64];
    assign o_out.last        = r_out_last;

    `XTS_ASSERT_NOW(a_no_accept_tw, w_accept, !w_tw_pending, "item taken while tweak pending")
    `XTS_ASSERT_NOW(a_no_accept_key, w_accept, !w_key_busy, "item taken during key rebuild")
    `XTS_ASSERT_NEXT(a_tw_tracked, w_accept && (i_in.kind == KIND_TWEAK), w_tw_pending, "tweak lost")

endmodule

### hdl/xts_key_sched.sv
// Runs the data key forward to its final round key for decryption
module xts_key_sched
    import xts_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_key,
    output logic [127:0] o_last_key,
    output logic         o_busy
);

    logic [3:0]   r_cnt;
    logic [3:0]   n_cnt;
    logic [127:0] r_key;
    logic [127:0] n_key;

    always_comb begin
        n_cnt = r_cnt;
        n_key = r_key;
        if (i_start) begin
            n_key = i_key;
            n_cnt = 4'd1;
        end else if (r_cnt != 4'd0) begin
            n_key = f_key_next(r_key, RCON[r_cnt]);
            n_cnt = (r_cnt == 4'(NUM_ROUNDS)) ? 4'd0 : r_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_key <= n_key;
    end

    assign o_last_key = r_key;
    assign o_busy     = i_start || (r_cnt != 4'd0);

endmodule

### hdl/xts_round_cell.sv
// One AES round cell: round transform plus on-the-fly round key
module xts_round_cell
    import xts_pkg::*;
#(
    parameter int ROUND = 1
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_cell i_d,
    output t_cell o_q
);

    localparam logic [7:0] ENC_RCON   = RCON[ROUND];
    localparam logic [7:0] DEC_RCON   = RCON[NUM_ROUNDS + 1 - ROUND];
    localparam bit         LAST_ROUND = (ROUND == NUM_ROUNDS);

    t_cell        r_q;
    t_cell        n_q;
    logic [127:0] w_sub_e;
    logic [127:0] w_mix_e;
    logic [127:0] w_sub_d;
    logic [127:0] w_add_d;
    logic [127:0] w_mix_d;
    logic [127:0] w_key_e;
    logic [127:0] w_key_d;

    // shift rows and byte substitution, both directions
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                w_sub_e[8*(i+4*c) +: 8] = SBOX[i_d.state[8*(i+4*((c+i)%4)) +: 8]];
                w_sub_d[8*(i+4*((c+i)%4)) +: 8] = INV_SBOX[i_d.state[8*(i+4*c) +: 8]];
            end
        end
    end

    assign w_key_e = f_key_next(i_d.rkey, ENC_RCON);
    assign w_key_d = f_key_prev(i_d.rkey, DEC_RCON);
    assign w_add_d = w_sub_d ^ w_key_d;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_mix_e[32*c +: 32] = LAST_ROUND ? w_sub_e[32*c +: 32] : f_mix_col(w_sub_e[32*c +: 32]);
            w_mix_d[32*c +: 32] = LAST_ROUND ? w_add_d[32*c +: 32]
                                             : f_inv_mix_col(w_add_d[32*c +: 32]);
        end
    end

    always_comb begin
        n_q = i_d;
        if (i_d.dec) begin
            n_q.state = w_mix_d;
            n_q.rkey  = w_key_d;
        end else begin
            n_q.state = w_mix_e ^ w_key_e;
            n_q.rkey  = w_key_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule
